[rtl/core/stlcd_pkg.sv]
`default_nettype none

package stlcd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LINE_W = 6;
	localparam int unsigned ROWS_W = 3;
	localparam int unsigned ROW_W = 2;
	localparam int unsigned OP_W = 2;

	localparam logic [LINE_W-1:0] LINE_RST = 6'd20;
	localparam logic [LINE_W-1:0] LINE_MAX = 6'd40;
	localparam logic [ROWS_W-1:0] ROWS_RST = 3'd4;
	localparam logic [ROWS_W-1:0] ROWS_MAX = 3'd4;

	localparam logic [BYTE_W-1:0] BYTE_TOGGLE = 8'd172;
	localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;
	localparam logic [BYTE_W-1:0] BYTE_LF = 8'd10;
	localparam logic [BYTE_W-1:0] BYTE_SPACE = 8'h20;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_CURSOR = 2'd1,
		OP_WRITE = 2'd2,
		OP_LIGHT = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		REG_LINE_LENGTH = 1'b0,
		REG_ROW_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		JK_CURSOR,
		JK_LIGHT,
		JK_PRINT
	} job_kind_t;

	typedef struct packed {
		logic clr0;
		job_kind_t kind;
		logic [ROW_W-1:0] row;
		logic blank_clr;
		logic blank_sp;
		logic [LINE_W-1:0] len;
		logic wrap;
		logic [ROW_W-1:0] wrap_row;
		logic [BYTE_W-1:0] ch;
		logic bl;
	} job_t;

endpackage

`default_nettype wire

[rtl/core/stlcd_front.sv]
`default_nettype none

module stlcd_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [stlcd_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic [stlcd_pkg::LINE_W-1:0] line_length,
	input  wire logic [stlcd_pkg::ROWS_W-1:0] row_count,
	input  wire logic q_full,
	output logic q_push,
	output stlcd_pkg::job_t q_job
);
	import stlcd_pkg::*;

	function automatic logic [LINE_W-1:0] eff_line(input logic [LINE_W-1:0] v);
		if (v == '0) return LINE_W'(1);
		if (v > LINE_MAX) return LINE_MAX;
		return v;
	endfunction

	function automatic logic [ROWS_W-1:0] eff_rows(input logic [ROWS_W-1:0] v);
		if (v == '0) return ROWS_W'(1);
		if (v > ROWS_MAX) return ROWS_MAX;
		return v;
	endfunction

	function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r,
			input logic [ROWS_W-1:0] rows);
		logic [ROWS_W-1:0] n;
		n = ROWS_W'(r) + ROWS_W'(1);
		if (n >= rows) return '0;
		return n[ROW_W-1:0];
	endfunction

	logic [ROW_W-1:0] cur_row_q, cur_row_d;
	logic [LINE_W-1:0] col_q, col_d;
	logic blank_q, blank_d;
	logic wrapped_q, wrapped_d;
	logic first_q, first_d;
	logic bl_q, bl_d;
	logic skip_q, skip_d;

	logic accept;
	logic [LINE_W-1:0] len;
	logic [ROWS_W-1:0] rows;
	logic [ROW_W-1:0] nr;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign len = eff_line(line_length);
	assign rows = eff_rows(row_count);
	assign nr = next_row(cur_row_q, rows);

	always_comb begin
		cur_row_d = cur_row_q;
		col_d = col_q;
		blank_d = blank_q;
		wrapped_d = wrapped_q;
		first_d = first_q;
		bl_d = bl_q;
		skip_d = skip_q;
		q_push = 1'b0;
		q_job = '0;
		q_job.clr0 = first_q;
		q_job.len = len;
		q_job.ch = rx_byte;
		if (accept) begin
			if (skip_q) begin
				skip_d = 1'b0;
			end else begin
				q_push = 1'b1;
				first_d = 1'b0;
				if (rx_byte == BYTE_CR) begin
					q_job.kind = JK_CURSOR;
					q_job.row = '0;
					cur_row_d = '0;
					blank_d = 1'b0;
					col_d = '0;
				end else if (rx_byte == BYTE_LF) begin
					q_job.kind = JK_CURSOR;
					q_job.row = nr;
					cur_row_d = nr;
					blank_d = 1'b1;
					col_d = '0;
				end else if (rx_byte == BYTE_TOGGLE) begin
					q_job.kind = JK_LIGHT;
					q_job.bl = !bl_q;
					bl_d = !bl_q;
					skip_d = 1'b1;
				end else begin
					q_job.kind = JK_PRINT;
					q_job.row = cur_row_q;
					if (blank_q) begin
						if (wrapped_q) begin
							q_job.blank_clr = 1'b1;
							wrapped_d = 1'b0;
						end else begin
							q_job.blank_sp = 1'b1;
						end
						blank_d = 1'b0;
					end
					if ((LINE_W+1)'(col_q) + (LINE_W+1)'(1) > (LINE_W+1)'(len)) begin
						q_job.wrap = 1'b1;
						q_job.wrap_row = nr;
						cur_row_d = nr;
						col_d = LINE_W'(1);
						wrapped_d = 1'b1;
					end else begin
						col_d = col_q + LINE_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			col_q <= '0;
			blank_q <= 1'b0;
			wrapped_q <= 1'b0;
			first_q <= 1'b1;
			bl_q <= 1'b1;
			skip_q <= 1'b0;
		end else begin
			cur_row_q <= cur_row_d;
			col_q <= col_d;
			blank_q <= blank_d;
			wrapped_q <= wrapped_d;
			first_q <= first_d;
			bl_q <= bl_d;
			skip_q <= skip_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/stlcd_queue.sv]
`default_nettype none

module stlcd_queue #(
	parameter int unsigned DEPTH = stlcd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire stlcd_pkg::job_t push_job,
	input  wire logic pop,
	output logic full,
	output logic head_valid,
	output stlcd_pkg::job_t head_job
);
	import stlcd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CNT_FULL);
	assign head_valid = (cnt_q != '0);
	assign head_job = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/stlcd_back.sv]
`default_nettype none

module stlcd_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	input  wire stlcd_pkg::job_t q_job,
	output logic q_pop,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [stlcd_pkg::OP_W-1:0] op,
	output logic [stlcd_pkg::ROW_W-1:0] row,
	output logic [stlcd_pkg::BYTE_W-1:0] char_code,
	output logic backlight_on,
	output logic last
);
	import stlcd_pkg::*;

	typedef enum logic [2:0] {
		PH_CLR0,
		PH_BCLR,
		PH_SPACE,
		PH_BCUR,
		PH_WCUR,
		PH_MAIN
	} phase_t;

	function automatic logic ph_en(input job_t j, input phase_t p);
		logic en;
		unique case (p) inside
			PH_CLR0: en = j.clr0;
			PH_BCLR: en = (j.kind == JK_PRINT) && j.blank_clr;
			PH_SPACE, PH_BCUR: en = (j.kind == JK_PRINT) && j.blank_sp;
			PH_WCUR: en = (j.kind == JK_PRINT) && j.wrap;
			PH_MAIN: en = 1'b1;
			default: en = 1'b0;
		endcase
		return en;
	endfunction

	function automatic phase_t ph_after(input job_t j, input phase_t p);
		phase_t r;
		r = PH_MAIN;
		for (int i = int'(PH_WCUR); i > int'(p); i--) begin
			if (ph_en(j, phase_t'(3'(i)))) r = phase_t'(3'(i));
		end
		return r;
	endfunction

	logic busy_q;
	phase_t ph_q;
	logic [LINE_W-1:0] cnt_q;

	logic out_valid_q;
	op_t op_q;
	logic [ROW_W-1:0] row_q;
	logic [BYTE_W-1:0] char_q;
	logic bl_q;
	logic last_q;

	phase_t cur_ph, nxt_ph;
	logic [LINE_W-1:0] cur_cnt;
	logic advance, in_run, done;
	op_t cmd_op;
	logic [ROW_W-1:0] cmd_row;
	logic [BYTE_W-1:0] cmd_char;
	logic cmd_bl;

	always_comb begin
		if (busy_q) begin
			cur_ph = ph_q;
			cur_cnt = cnt_q;
		end else begin
			cur_ph = q_job.clr0 ? PH_CLR0 : ph_after(q_job, PH_CLR0);
			cur_cnt = '0;
		end
		nxt_ph = ph_after(q_job, cur_ph);
		in_run = (cur_ph == PH_SPACE) &&
			((LINE_W+1)'(cur_cnt) + (LINE_W+1)'(1) < (LINE_W+1)'(q_job.len));
		done = (cur_ph == PH_MAIN);
		advance = q_valid && (!out_valid_q || !out_stall);
		q_pop = advance && done;

		cmd_op = OP_CLEAR;
		cmd_row = '0;
		cmd_char = '0;
		cmd_bl = 1'b0;
		unique case (cur_ph)
			PH_CLR0, PH_BCLR: cmd_op = OP_CLEAR;
			PH_SPACE: begin
				cmd_op = OP_WRITE;
				cmd_char = BYTE_SPACE;
			end
			PH_BCUR: begin
				cmd_op = OP_CURSOR;
				cmd_row = q_job.row;
			end
			PH_WCUR: begin
				cmd_op = OP_CURSOR;
				cmd_row = q_job.wrap_row;
			end
			PH_MAIN: begin
				unique case (q_job.kind)
					JK_CURSOR: begin
						cmd_op = OP_CURSOR;
						cmd_row = q_job.row;
					end
					JK_LIGHT: begin
						cmd_op = OP_LIGHT;
						cmd_bl = q_job.bl;
					end
					JK_PRINT: begin
						cmd_op = OP_WRITE;
						cmd_char = q_job.ch;
					end
					default: cmd_op = OP_CLEAR;
				endcase
			end
			default: cmd_op = OP_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= PH_CLR0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				busy_q <= !done;
				ph_q <= in_run ? cur_ph : nxt_ph;
				cnt_q <= in_run ? cur_cnt + LINE_W'(1) : '0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_q <= cmd_op;
			row_q <= cmd_row;
			char_q <= cmd_char;
			bl_q <= cmd_bl;
			last_q <= done;
		end
	end

	assign out_valid = out_valid_q;
	assign op = op_q;
	assign row = row_q;
	assign char_code = char_q;
	assign backlight_on = bl_q;
	assign last = last_q;

endmodule

`default_nettype wire

[rtl/core/serial_text_to_char_lcd_sequencer_core.sv]
// The first command of an item reaches the output through the item queue and the output register.
// Throughput: one command per cycle from the output register while out_stall is low; an item
// occupies the command generator until all of its commands (1 to 42) are issued.
// Input is taken every cycle while the item queue (QUEUE_DEPTH entries) has room.
// Reset is asynchronous, active low: queue empty, line length 20, four rows,
// backlight on, first item clears the screen.
`default_nettype none

module serial_text_to_char_lcd_sequencer_core #(
	parameter int unsigned QUEUE_DEPTH = stlcd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [stlcd_pkg::BYTE_W-1:0] rx_byte,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [stlcd_pkg::OP_W-1:0] op,
	output logic [stlcd_pkg::ROW_W-1:0] row,
	output logic [stlcd_pkg::BYTE_W-1:0] char_code,
	output logic backlight_on,
	output logic last,
	input  wire logic wr_en,
	input  wire logic [0:0] wr_index,
	input  wire logic [stlcd_pkg::LINE_W-1:0] wr_data
);
	import stlcd_pkg::*;

	logic [LINE_W-1:0] line_length_q;
	logic [ROWS_W-1:0] row_count_q;

	logic q_full, q_push, q_pop, q_valid;
	job_t push_job, head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_RST;
			row_count_q <= ROWS_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_LINE_LENGTH: line_length_q <= wr_data;
				REG_ROW_COUNT: row_count_q <= wr_data[ROWS_W-1:0];
				default: line_length_q <= line_length_q;
			endcase
		end
	end

	stlcd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.line_length(line_length_q),
		.row_count(row_count_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_job(push_job)
	);

	stlcd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_job(push_job),
		.pop(q_pop),
		.full(q_full),
		.head_valid(q_valid),
		.head_job(head_job)
	);

	stlcd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_job(head_job),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.op(op),
		.row(row),
		.char_code(char_code),
		.backlight_on(backlight_on),
		.last(last)
	);

endmodule

`default_nettype wire

[rtl/core/stlcd_checker.sv]
`default_nettype none

module stlcd_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_stall,
	input  wire logic [stlcd_pkg::BYTE_W-1:0] rx_byte,
	input  wire logic out_valid,
	input  wire logic out_stall,
	input  wire logic [stlcd_pkg::OP_W-1:0] op,
	input  wire logic [stlcd_pkg::ROW_W-1:0] row,
	input  wire logic [stlcd_pkg::BYTE_W-1:0] char_code,
	input  wire logic backlight_on,
	input  wire logic last
);
	import stlcd_pkg::*;

	// hold a stalled item
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte))
		else $error("stalled input item changed");

	// hold a stalled command
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(op) && $stable(row) &&
			$stable(char_code) && $stable(backlight_on) && $stable(last))
		else $error("stalled command changed");

	// blanking spaces run without gaps
	a_space_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && op == OP_WRITE && !last |=> out_valid)
		else $error("gap inside a command run");

	a_space_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op == OP_WRITE && !last |-> char_code == BYTE_SPACE)
		else $error("non-final write is not a space");

	a_light_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op == OP_LIGHT |-> last && row == '0 && char_code == '0)
		else $error("backlight command not final or fields not clear");

endmodule

bind serial_text_to_char_lcd_sequencer_core stlcd_checker u_stlcd_checker (.*);

`default_nettype wire
